[rtl/core/csvp_pkg.sv]
// csvp_pkg: shared types, character constants and helper functions of the
// csv record field parser; no dependencies, used by every module of the block
package csvp_pkg;

   // character constants
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   // result field widths
   localparam int ERR_OFF_W = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // csr register indexes
   localparam logic [1:0] CSR_DELIMITER       = 2'd0;
   localparam logic [1:0] CSR_ESCAPE_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_ACCEPT_UNQUOTED = 2'd2;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_UNQUOTED = 2'd1,
      ERR_QUOTE    = 2'd2,
      ERR_EARLY    = 2'd3
   } err_type;

   // one word as the front hands it over; second marks a trailing empty field
   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 has_byte;
      logic                 field_done;
      logic                 record_done;
      err_type              error_code;
      logic [ERR_OFF_W-1:0] error_offset;
      logic                 second;
   } entry_type;

   // one word on the result channel
   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 has_byte;
      logic                 field_done;
      logic                 record_done;
      err_type              error_code;
      logic [ERR_OFF_W-1:0] error_offset;
      logic                 last_result;
   } result_type;

   // backslash escape decode
   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_N:    r = 8'h0A;
         CH_R:    r = 8'h0D;
         CH_B:    r = 8'h08;
         CH_T:    r = 8'h09;
         CH_ZERO: r = 8'h00;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/csvp_front.sv]
// csvp_front: byte classifier with the parse state machine and byte offset;
// depends on csvp_pkg, feeds csvp_queue with one word per byte that has results
module csvp_front #(
   parameter int OFFSET_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               end_of_record,
   input  logic [7:0]         delimiter,
   input  logic               escape_enable,
   input  logic               accept_unquoted,
   output logic               push,
   output csvp_pkg::entry_type entry
);
   import csvp_pkg::*;

   typedef enum logic [5:0] {
      PH_START  = 6'b000001,
      PH_UNQ    = 6'b000010,
      PH_QUOTED = 6'b000100,
      PH_QSEEN  = 6'b001000,
      PH_ESC    = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

   phase_type              phase_ff, phase_in, next_phase;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [ERR_OFF_W-1:0]   off16;
   logic                   is_delim, is_quote;

   assign off16    = ERR_OFF_W'(offset_ff);
   assign is_delim = (in_byte == delimiter);
   assign is_quote = (in_byte == CH_QUOTE);

   // classify the byte against the current phase
   always_comb begin
      push       = 1'b0;
      entry      = '0;
      next_phase = phase_ff;
      unique case (phase_ff)
         PH_START, PH_UNQ: begin
            if (is_delim) begin
               push             = 1'b1;
               entry.field_done = 1'b1;
               entry.second     = end_of_record;
               next_phase       = PH_START;
            end else if (phase_ff == PH_START && is_quote) begin
               if (end_of_record) begin
                  push               = 1'b1;
                  entry.record_done  = 1'b1;
                  entry.error_code   = ERR_EARLY;
                  entry.error_offset = off16;
               end
               next_phase = PH_QUOTED;
            end else if (phase_ff == PH_UNQ || accept_unquoted) begin
               push              = 1'b1;
               entry.out_byte    = in_byte;
               entry.has_byte    = 1'b1;
               entry.field_done  = end_of_record;
               entry.record_done = end_of_record;
               next_phase        = PH_UNQ;
            end else begin
               push               = 1'b1;
               entry.record_done  = end_of_record;
               entry.error_code   = ERR_UNQUOTED;
               entry.error_offset = off16;
               next_phase         = PH_SKIP;
            end
         end
         PH_QUOTED: begin
            if (is_quote) begin
               if (end_of_record) begin
                  push              = 1'b1;
                  entry.field_done  = 1'b1;
                  entry.record_done = 1'b1;
               end
               next_phase = PH_QSEEN;
            end else if (end_of_record) begin
               push               = 1'b1;
               entry.record_done  = 1'b1;
               entry.error_code   = ERR_EARLY;
               entry.error_offset = off16;
            end else if (in_byte == CH_BSLASH && escape_enable) begin
               next_phase = PH_ESC;
            end else begin
               push           = 1'b1;
               entry.out_byte = in_byte;
               entry.has_byte = 1'b1;
            end
         end
         PH_QSEEN: begin
            if (is_quote) begin
               push = 1'b1;
               if (end_of_record) begin
                  entry.record_done  = 1'b1;
                  entry.error_code   = ERR_EARLY;
                  entry.error_offset = off16;
               end else begin
                  entry.out_byte = CH_QUOTE;
                  entry.has_byte = 1'b1;
               end
               next_phase = PH_QUOTED;
            end else if (is_delim) begin
               push             = 1'b1;
               entry.field_done = 1'b1;
               entry.second     = end_of_record;
               next_phase       = PH_START;
            end else begin
               push               = 1'b1;
               entry.record_done  = end_of_record;
               entry.error_code   = ERR_QUOTE;
               entry.error_offset = off16;
               next_phase         = PH_SKIP;
            end
         end
         PH_ESC: begin
            push = 1'b1;
            if (end_of_record) begin
               entry.record_done  = 1'b1;
               entry.error_code   = ERR_EARLY;
               entry.error_offset = off16;
            end else begin
               entry.out_byte = unescape(in_byte);
               entry.has_byte = 1'b1;
            end
            next_phase = PH_QUOTED;
         end
         PH_SKIP: begin
            if (end_of_record) begin
               push              = 1'b1;
               entry.record_done = 1'b1;
            end
            next_phase = PH_SKIP;
         end
         default: begin
            next_phase = PH_START;
         end
      endcase
      if (!accept) begin
         push = 1'b0;
      end
   end

   // phase and saturating offset, both cleared at record end
   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      if (accept) begin
         if (end_of_record) begin
            phase_in  = PH_START;
            offset_in = '0;
         end else begin
            phase_in = next_phase;
            if (offset_ff != '1) begin
               offset_in = offset_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         offset_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
      end
   end

endmodule

[rtl/core/csvp_queue.sv]
// csvp_queue: short first-in first-out queue of words between front and back;
// depends on csvp_pkg for the word type and depth
module csvp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvp_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output csvp_pkg::entry_type head
);
   import csvp_pkg::*;

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/csvp_back.sv]
// csvp_back: result stage that turns queue words into result words, adding
// the trailing empty field; depends on csvp_pkg, reads csvp_queue
module csvp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  csvp_pkg::entry_type  q_head,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output csvp_pkg::result_type result
);
   import csvp_pkg::*;

   result_type result_ff, result_in;
   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic       load;

   assign empty  = !valid_ff;
   assign result = result_ff;
   assign load   = !valid_ff || pop;

   // refill the output register when it is free or being taken
   always_comb begin
      result_in = result_ff;
      valid_in  = valid_ff;
      pend_in   = pend_ff;
      q_pop     = 1'b0;
      if (load) begin
         if (pend_ff) begin
            result_in             = '0;
            result_in.field_done  = 1'b1;
            result_in.record_done = 1'b1;
            result_in.last_result = 1'b1;
            valid_in              = 1'b1;
            pend_in               = 1'b0;
         end else if (q_not_empty) begin
            q_pop                  = 1'b1;
            result_in.out_byte     = q_head.out_byte;
            result_in.has_byte     = q_head.has_byte;
            result_in.field_done   = q_head.field_done;
            result_in.record_done  = q_head.record_done;
            result_in.error_code   = q_head.error_code;
            result_in.error_offset = q_head.error_offset;
            result_in.last_result  = !q_head.second;
            valid_in               = 1'b1;
            pend_in                = q_head.second;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

[rtl/core/csv_record_field_parser.sv]
// csv_record_field_parser: top level with the csr registers, front parser,
// word queue and result stage; depends on csvp_pkg, csvp_front, csvp_queue, csvp_back
//
// usage: raw record bytes enter on the req_ queue port (req_push/req_full),
// one byte per word, with req_end_of_record on the record's final byte.
// decoded words leave on the rsp_ queue port (rsp_empty/rsp_pop): a field
// byte, field and record end marks, an error code with its byte offset, and
// last_result on the final word caused by an input byte. a byte gives zero,
// one or two words; a delimiter on the last byte gives two.
// a byte's word is written into the queue and then into the result stage register.
// throughput: one byte per cycle while req_full is low; a byte with two words
// holds the result stage for both words, which the four-word queue absorbs
// between front and back. when the receiver stalls, the queue fills and req_full
// rises; bytes with no word never take a queue slot.
// reset clears the parse phase, the offset, the queue and the result stage,
// and loads delimiter ',', escapes off and unquoted fields accepted.
// csr registers (write only while idle): 0x0 delimiter, 0x4 escape_enable,
// 0x8 accept_unquoted.
module csv_record_field_parser #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_record,
   // result output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_byte,
   output logic        rsp_field_done,
   output logic        rsp_record_done,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_error_offset,
   output logic        rsp_last_result,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import csvp_pkg::*;

   logic [7:0] delimiter_ff;
   logic       escape_enable_ff;
   logic       accept_unquoted_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   logic       accept;
   logic       front_push;
   entry_type  front_entry;
   logic       q_full, q_not_empty, q_pop;
   entry_type  q_head;
   result_type result;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff       <= CH_COMMA;
         escape_enable_ff   <= 1'b0;
         accept_unquoted_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DELIMITER:       delimiter_ff       <= csr_pwdata[7:0];
            CSR_ESCAPE_ENABLE:   escape_enable_ff   <= csr_pwdata[0];
            CSR_ACCEPT_UNQUOTED: accept_unquoted_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_DELIMITER:       csr_prdata = {24'b0, delimiter_ff};
         CSR_ESCAPE_ENABLE:   csr_prdata = {31'b0, escape_enable_ff};
         CSR_ACCEPT_UNQUOTED: csr_prdata = {31'b0, accept_unquoted_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // input handshake
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   csvp_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .end_of_record   (req_end_of_record),
      .delimiter       (delimiter_ff),
      .escape_enable   (escape_enable_ff),
      .accept_unquoted (accept_unquoted_ff),
      .push            (front_push),
      .entry           (front_entry)
   );

   csvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   csvp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .pop         (rsp_pop),
      .empty       (rsp_empty),
      .result      (result)
   );

   // result ports
   assign rsp_out_byte     = result.out_byte;
   assign rsp_has_byte     = result.has_byte;
   assign rsp_field_done   = result.field_done;
   assign rsp_record_done  = result.record_done;
   assign rsp_error_code   = result.error_code;
   assign rsp_error_offset = result.error_offset;
   assign rsp_last_result  = result.last_result;

endmodule
